// File: design/sps_pkg.sv
// shared types and constants for the payload splitter
// no dependencies; imported by every module of the block
`default_nettype none
package sps_pkg;

	// field widths
	localparam int LEN_W   = 16;
	localparam int TOT_W   = LEN_W + 1;
	localparam int CFG_IDX_W = 1;

	// default packet count limit
	localparam int MAX_PACKETS = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_REDUCTION = 1'd1;

	// configuration reset values
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST    = 16'd1200;
	localparam logic [LEN_W-1:0] LAST_REDUCTION_RST = 16'd0;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_LIMITS   = 2'd1,
		STATUS_TOO_MANY = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic div1_start;
		logic take_left;
		logic div2_start;
		logic take_split;
		logic emit;
		logic err_load;
		status_t err_status;
	} sps_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic limits_bad;
		logic payload_zero;
		logic div_done;
		logic too_many;
		logic step_last;
		logic out_free;
	} sps_stat_t;

endpackage
`default_nettype wire

// File: design/sps_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on sps_pkg for the operand width
`default_nettype none
module sps_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire  [sps_pkg::TOT_W-1:0] dividend,
	input  wire  [sps_pkg::TOT_W-1:0] divisor,
	output logic                      done,
	output logic [sps_pkg::TOT_W-1:0] quotient,
	output logic [sps_pkg::TOT_W-1:0] remainder
);
	import sps_pkg::*;

	localparam int CNT_W = $clog2(TOT_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [TOT_W-1:0] quo_q;
	logic [TOT_W-1:0] rem_q;
	logic [TOT_W-1:0] dvs_q;
	logic [TOT_W:0]   shifted;
	logic [TOT_W:0]   diff;
	logic             ge;

	// one trial subtraction
	always_comb begin
		shifted = {rem_q, quo_q[TOT_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(TOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// quotient and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[TOT_W-2:0], ge};
			rem_q <= ge ? diff[TOT_W-1:0] : shifted[TOT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// File: design/sps_datapath.sv
// datapath: config registers, divider, split registers and output register
// depends on sps_pkg and sps_div
`default_nettype none
module sps_datapath #(
	parameter int MaxPackets = sps_pkg::MAX_PACKETS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  sps_pkg::sps_cmd_t       cmd,
	output sps_pkg::sps_stat_t            stat,
	input  wire                           cfg_write,
	input  wire  [sps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [sps_pkg::LEN_W-1:0]     cfg_data,
	input  wire  [sps_pkg::LEN_W-1:0]     frame_len,
	output logic [sps_pkg::LEN_W-1:0]     packet_bytes,
	output logic                          last_packet,
	output logic [1:0]                    status,
	output logic                          out_valid,
	input  wire                           out_ready
);
	import sps_pkg::*;

	localparam int LW = $clog2(MaxPackets + 1);

	logic [LEN_W-1:0] maxp_q;
	logic [LEN_W-1:0] red_q;
	logic [LEN_W-1:0] payload_q;
	logic [TOT_W-1:0] total_q;
	logic [LW-1:0]    left_q;
	logic [LW-1:0]    larger_q;
	logic [TOT_W-1:0] per_q;
	logic [LEN_W-1:0] remaining_q;

	logic             out_valid_q;
	logic [LEN_W-1:0] bytes_q;
	logic             last_q;
	status_t          status_q;

	logic [TOT_W-1:0] div_dividend;
	logic [TOT_W-1:0] div_divisor;
	logic             div_done;
	logic [TOT_W-1:0] div_quo;
	logic [TOT_W-1:0] div_rem;
	logic [TOT_W:0]   left_full;

	logic [TOT_W-1:0] per_eff;
	logic [LEN_W-1:0] cur_clip;
	logic [LEN_W-1:0] cur;
	logic [LEN_W-1:0] rem_next;
	logic [LW-1:0]    left_next;
	logic             out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxp_q <= MAX_PAYLOAD_RST;
			red_q  <= LAST_REDUCTION_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MAX_PAYLOAD:    maxp_q <= cfg_data;
				CFG_LAST_REDUCTION: red_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared divider: total / max first, then total / packet count
	assign div_dividend = total_q;
	assign div_divisor  = cmd.div2_start ? TOT_W'(left_q) : TOT_W'(maxp_q);

	sps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div1_start | cmd.div2_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// rounded-up packet count
	assign left_full = {1'b0, div_quo} + (TOT_W + 1)'(div_rem != '0);

	// one packet step
	always_comb begin
		per_eff   = (left_q == larger_q) ? per_q + TOT_W'(1) : per_q;
		cur_clip  = (per_eff > TOT_W'(remaining_q)) ? remaining_q : per_eff[LEN_W-1:0];
		cur       = ((left_q == LW'(2)) && (cur_clip == remaining_q))
		            ? cur_clip - LEN_W'(1) : cur_clip;
		rem_next  = remaining_q - cur;
		left_next = left_q - LW'(1);
	end

	// split working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			payload_q   <= frame_len;
			total_q     <= TOT_W'(frame_len) + TOT_W'(red_q);
			remaining_q <= frame_len;
		end
		if (cmd.take_left) begin
			left_q <= left_full[LW-1:0];
		end
		if (cmd.take_split) begin
			per_q    <= div_quo;
			larger_q <= div_rem[LW-1:0];
		end
		if (cmd.emit) begin
			per_q       <= per_eff;
			remaining_q <= rem_next;
			left_q      <= left_next;
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.err_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			bytes_q  <= cur;
			last_q   <= (rem_next == '0) || (left_next == '0);
			status_q <= STATUS_OK;
		end else if (cmd.err_load) begin
			bytes_q  <= '0;
			last_q   <= 1'b1;
			status_q <= cmd.err_status;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// status toward the controller
	always_comb begin
		stat.limits_bad   = (maxp_q <= red_q);
		stat.payload_zero = (payload_q == '0);
		stat.div_done     = div_done;
		stat.too_many     = (left_full > (TOT_W + 1)'(MaxPackets));
		stat.step_last    = (rem_next == '0) || (left_next == '0);
		stat.out_free     = out_free;
	end

	assign packet_bytes = bytes_q;
	assign last_packet  = last_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;

endmodule
`default_nettype wire

// File: design/sps_ctrl.sv
// controller state machine sequencing check, two divisions, emission and error results
// depends on sps_pkg for command and status structs
`default_nettype none
module sps_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire  sps_pkg::sps_stat_t stat,
	output sps_pkg::sps_cmd_t  cmd
);
	import sps_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_CHECK    = 8'b0000_0010,
		ST_DIV1     = 8'b0000_0100,
		ST_START2   = 8'b0000_1000,
		ST_DIV2     = 8'b0001_0000,
		ST_EMIT     = 8'b0010_0000,
		ST_ERR_LIM  = 8'b0100_0000,
		ST_ERR_MANY = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and commands
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.err_status = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.limits_bad) begin
					state_d = ST_ERR_LIM;
				end else if (stat.payload_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.div1_start = 1'b1;
					state_d        = ST_DIV1;
				end
			end
			ST_DIV1: begin
				if (stat.div_done) begin
					if (stat.too_many) begin
						state_d = ST_ERR_MANY;
					end else begin
						cmd.take_left = 1'b1;
						state_d       = ST_START2;
					end
				end
			end
			ST_START2: begin
				cmd.div2_start = 1'b1;
				state_d        = ST_DIV2;
			end
			ST_DIV2: begin
				if (stat.div_done) begin
					cmd.take_split = 1'b1;
					state_d        = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.step_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR_LIM: begin
				cmd.err_status = STATUS_LIMITS;
				if (stat.out_free) begin
					cmd.err_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ERR_MANY: begin
				cmd.err_status = STATUS_TOO_MANY;
				if (stat.out_free) begin
					cmd.err_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: design/split_payload_about_equally_core.sv
// top level of the payload splitter: controller plus datapath
// depends on sps_pkg, sps_ctrl, sps_datapath
//
// channel   direction  payload
// s_axis    in         tdata[15:0] frame_len
// m_axis    out        tdata[15:0] packet_bytes, tlast last_packet, tuser[1:0] status
// cfg       in         cfg_index register index, cfg_data 16-bit value
//
// a frame passes an accept state, a check state, the two 17-step divisions
// through the shared divider and a setup state, then emits one packet per
// cycle while m_axis is not stalled; errors and zero payloads end earlier
// reset restores max_packet_payload 1200 and last_packet_reduction 0
// a stalled m_axis holds the sequencer; a new frame is taken while the final
// result of the previous one still waits in the output register
`default_nettype none
module split_payload_about_equally_core #(
	parameter int MaxPackets = sps_pkg::MAX_PACKETS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [15:0]                   s_axis_tdata,   // [15:0] frame_len
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	output logic [15:0]                   m_axis_tdata,   // [15:0] packet_bytes
	output logic                          m_axis_tlast,
	output logic [1:0]                    m_axis_tuser,   // [1:0] status
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [sps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [sps_pkg::LEN_W-1:0]     cfg_data
);
	import sps_pkg::*;

	sps_cmd_t  cmd;
	sps_stat_t stat;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	sps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sps_datapath #(
		.MaxPackets (MaxPackets)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write    (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frame_len    (s_axis_tdata),
		.packet_bytes (m_axis_tdata),
		.last_packet  (m_axis_tlast),
		.status       (m_axis_tuser),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready)
	);

`ifndef ASSERT_OFF
	// an error result is a single zero-size transfer flagged last
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tlast && (m_axis_tdata == '0)))
		else $error("error result not a single last zero-size transfer");

	// no new frame is taken while a packet is being produced
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !(cmd.emit || cmd.err_load))
		else $error("input ready while producing a result");

	// the divider finishes only while a frame is in progress
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> !s_axis_tready)
		else $error("divider finished while idle");

	// a packet is loaded only when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.err_load) |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten before transfer");
`endif

endmodule
`default_nettype wire
